// ===== sv/mps_pkg.sv =====
package mps_pkg;

  localparam int ROM_LEN = 12;
  localparam int ROM_IDX_W = 4;

  localparam logic [1:0] OP_POLL = 2'd0;
  localparam logic [1:0] OP_ON   = 2'd1;
  localparam logic [1:0] OP_OFF  = 2'd2;

  localparam logic [1:0] CHG_BUSY = 2'd0;
  localparam logic [1:0] CHG_DONE = 2'd1;

  localparam logic [1:0] FIRE_NONE = 2'd0;
  localparam logic [1:0] FIRE_POS  = 2'd1;
  localparam logic [1:0] FIRE_NEG  = 2'd2;

  localparam logic [2:0] REG_MIN_ON      = 3'd0;
  localparam logic [2:0] REG_MAX_PULSES  = 3'd1;
  localparam logic [2:0] REG_OFF_SKIP    = 3'd2;
  localparam logic [2:0] REG_ON_VOLTS    = 3'd3;
  localparam logic [2:0] REG_REFILL      = 3'd4;
  localparam logic [2:0] REG_CREDIT_MAX  = 3'd5;
  localparam logic [2:0] REG_RESID_FAIL  = 3'd6;

  localparam int CFG_DATA_W = 15;

  localparam logic signed [15:0] CREDIT_RESET = 16'sd13000;
  localparam logic signed [15:0] CREDIT_MIN   = 16'sh8000;

  typedef struct packed {
    logic [7:0]  min_on_pulses;
    logic [7:0]  max_pulses;
    logic [3:0]  off_skip_steps;
    logic [8:0]  on_charge_volts;
    logic [11:0] credit_refill;
    logic [14:0] credit_max;
    logic [9:0]  residual_fail_volts;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pulse_count;
    logic       refill_due;
    logic [1:0] charger_state;
    logic [5:0] charger_errors;
    logic [9:0] residual_volts;
  } item_t;

  typedef struct packed {
    logic [8:0]        charge_target_volts;
    logic [1:0]        fire;
    logic              magnet_on;
    logic              health_error;
    logic [5:0]        charger_errors_seen;
    logic              switching_on;
    logic              switching_off;
    logic signed [15:0] duty_credit;
  } res_t;

  function automatic logic [8:0] off_volts(input logic [ROM_IDX_W-1:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd475;
      4'd1:    v = 9'd435;
      4'd2:    v = 9'd400;
      4'd3:    v = 9'd370;
      4'd4:    v = 9'd335;
      4'd5:    v = 9'd310;
      4'd6:    v = 9'd280;
      4'd7:    v = 9'd240;
      4'd8:    v = 9'd215;
      4'd9:    v = 9'd190;
      4'd10:   v = 9'd175;
      default: v = 9'd150;
    endcase
    return v;
  endfunction

  function automatic logic off_pos(input logic [ROM_IDX_W-1:0] idx);
    logic p;
    case (idx)
      4'd2, 4'd4, 4'd6, 4'd8, 4'd10: p = 1'b1;
      default:                       p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/mps_cfg.sv =====
module mps_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [2:0]                       cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output mps_pkg::cfg_t                    cfg
);
  import mps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_on_pulses       <= 8'd1;
      cfg.max_pulses          <= 8'd10;
      cfg.off_skip_steps      <= 4'd0;
      cfg.on_charge_volts     <= 9'd475;
      cfg.credit_refill       <= 12'd180;
      cfg.credit_max          <= 15'd13000;
      cfg.residual_fail_volts <= 10'd100;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_ON:     cfg.min_on_pulses       <= cfg_wdata[7:0];
        REG_MAX_PULSES: cfg.max_pulses          <= cfg_wdata[7:0];
        REG_OFF_SKIP:   cfg.off_skip_steps      <= cfg_wdata[3:0];
        REG_ON_VOLTS:   cfg.on_charge_volts     <= cfg_wdata[8:0];
        REG_REFILL:     cfg.credit_refill       <= cfg_wdata[11:0];
        REG_CREDIT_MAX: cfg.credit_max          <= cfg_wdata[14:0];
        REG_RESID_FAIL: cfg.residual_fail_volts <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mps_core.sv =====
module mps_core #(
  parameter int OFF_STEPS = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  mps_pkg::cfg_t  cfg,
  input  mps_pkg::item_t item,
  input  logic           step,
  output mps_pkg::res_t  res
);
  import mps_pkg::*;

  localparam logic [8:0] OFF_STEPS_W = 9'(OFF_STEPS);
  localparam logic [8:0] ROM_LEN_W   = 9'(ROM_LEN);

  logic signed [8:0]  pulses_left;
  logic signed [15:0] credit;
  logic               magnet_state;
  logic               health_flag;
  logic [5:0]         last_charger_errors;

  logic signed [8:0]  pulses_left_next;
  logic signed [15:0] credit_next;
  logic               magnet_state_next;
  logic               health_flag_next;
  logic [5:0]         last_charger_errors_next;

  logic [7:0]         on_lo;
  logic [7:0]         on_n;
  logic [8:0]         skip;
  logic [8:0]         rom_sum;
  logic [ROM_IDX_W-1:0] rom_idx;
  logic signed [16:0] credit_sum;
  logic signed [16:0] credit_ceil;
  logic signed [15:0] credit_filled;
  logic               turning_on;
  logic               pos;
  logic [8:0]         target;
  logic [1:0]         fire;

  always_comb begin
    on_lo = (item.pulse_count < cfg.min_on_pulses) ? cfg.min_on_pulses : item.pulse_count;
    on_n  = (on_lo > cfg.max_pulses) ? cfg.max_pulses : on_lo;

    skip = 9'd0;
    if (!magnet_state) begin
      skip = ({5'd0, cfg.off_skip_steps} > OFF_STEPS_W) ? OFF_STEPS_W
                                                         : {5'd0, cfg.off_skip_steps};
    end

    rom_sum = OFF_STEPS_W + pulses_left;
    rom_idx = (rom_sum >= ROM_LEN_W) ? ROM_IDX_W'(ROM_LEN - 1) : rom_sum[ROM_IDX_W-1:0];

    credit_sum  = {credit[15], credit} + $signed({5'd0, cfg.credit_refill});
    credit_ceil = $signed({2'd0, cfg.credit_max});
    credit_filled = credit;
    if (item.refill_due) begin
      credit_filled = (credit_sum > credit_ceil) ? credit_ceil[15:0] : credit_sum[15:0];
    end

    turning_on = (pulses_left > 9'sd0);
    pos        = turning_on ? 1'b1 : off_pos(rom_idx);

    pulses_left_next         = pulses_left;
    credit_next              = credit;
    magnet_state_next        = magnet_state;
    health_flag_next         = health_flag;
    last_charger_errors_next = last_charger_errors;
    target                   = 9'd0;
    fire                     = FIRE_NONE;

    case (item.op)
      OP_ON, OP_OFF: begin
        if (pulses_left == 9'sd0 && !credit[15]) begin
          if (item.op == OP_ON) begin
            pulses_left_next = $signed({1'b0, on_n});
          end else begin
            pulses_left_next = $signed(9'd0 - (OFF_STEPS_W - skip));
          end
        end
      end
      OP_POLL: begin
        credit_next = credit_filled;
        if (pulses_left != 9'sd0) begin
          target = turning_on ? cfg.on_charge_volts : off_volts(rom_idx);
          last_charger_errors_next = item.charger_errors;
          case (item.charger_state)
            CHG_BUSY: begin
              if (credit_filled != CREDIT_MIN) begin
                credit_next = credit_filled - 16'sd1;
              end
            end
            CHG_DONE: begin
              fire = pos ? FIRE_POS : FIRE_NEG;
              magnet_state_next = turning_on;
              if (item.residual_volts > cfg.residual_fail_volts) begin
                pulses_left_next = 9'sd0;
                health_flag_next = 1'b1;
              end else begin
                pulses_left_next = turning_on ? pulses_left - 9'sd1 : pulses_left + 9'sd1;
                health_flag_next = 1'b0;
              end
            end
            default: begin
              pulses_left_next = 9'sd0;
              health_flag_next = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase

    res.charge_target_volts = target;
    res.fire                = fire;
    res.magnet_on           = magnet_state_next;
    res.health_error        = health_flag_next;
    res.charger_errors_seen = last_charger_errors_next;
    res.switching_on        = (pulses_left_next > 9'sd0);
    res.switching_off       = pulses_left_next[8];
    res.duty_credit         = credit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_left         <= 9'sd0;
      credit              <= CREDIT_RESET;
      magnet_state        <= 1'b0;
      health_flag         <= 1'b0;
      last_charger_errors <= 6'd0;
    end else if (step) begin
      pulses_left         <= pulses_left_next;
      credit              <= credit_next;
      magnet_state        <= magnet_state_next;
      health_flag         <= health_flag_next;
      last_charger_errors <= last_charger_errors_next;
    end
  end

endmodule

// ===== sv/magnet_pulse_sequencer_unit.sv =====
// Pulse sequencer for an electropermanent magnet. Each request (poll, turn-on
// or turn-off command) yields exactly one result. A request is captured in an
// input register, the sequencer state is updated by one pass of next-state
// logic and the result is held in an output register. While the output register
// holds a result that is not yet taken, the request waits in the input register.
// One request can be accepted every cycle while the output is not stalled.
// Configuration writes take effect at the next clock edge and are meant to
// happen while no request is in flight.
module magnet_pulse_sequencer_unit #(
  parameter int OFF_STEPS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pulse_count[7:0], refill_due[8], charger_state[10:9], charger_errors[16:11],
  // residual_volts[26:17], zero [31:27]
  input  logic [31:0]                    s_tdata,
  // op[1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // charge_target_volts[8:0], fire[10:9], magnet_on[11], health_error[12],
  // charger_errors_seen[18:13], switching_on[19], switching_off[20],
  // duty_credit[36:21], zero [39:37]
  output logic [39:0]                    m_tdata,
  input  logic                           cfg_wr_en,
  input  logic [2:0]                     cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mps_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  res_t  res_r;
  logic  in_valid;
  logic  advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.op             <= s_tuser;
      item.pulse_count    <= s_tdata[7:0];
      item.refill_due     <= s_tdata[8];
      item.charger_state  <= s_tdata[10:9];
      item.charger_errors <= s_tdata[16:11];
      item.residual_volts <= s_tdata[26:17];
    end
  end

  mps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mps_core #(
    .OFF_STEPS (OFF_STEPS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .step (advance),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign m_tdata = {3'd0,
                    res_r.duty_credit,
                    res_r.switching_off,
                    res_r.switching_on,
                    res_r.charger_errors_seen,
                    res_r.health_error,
                    res_r.magnet_on,
                    res_r.fire,
                    res_r.charge_target_volts};

endmodule

// ===== verif/magnet_sequencer_monitor.sv =====
`timescale 1ns / 1ps

module magnet_sequencer_monitor
  import mps_pkg::*;
#(
  parameter int OFF_STEP_COUNT = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [31:0]                    s_tdata,
  input  logic [1:0]                     s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [39:0]                    m_tdata,
  input  logic                           cfg_wr_en,
  input  logic [2:0]                     cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             pending_count,
  output int                             fail_count,
  output int                             checked_count,
  output int                             fired_count
);

  localparam logic [8:0] DISCHARGE_VOLTS [0:11] = '{
    9'd475, 9'd435, 9'd400, 9'd370, 9'd335, 9'd310,
    9'd280, 9'd240, 9'd215, 9'd190, 9'd175, 9'd150
  };
  localparam logic [11:0] DISCHARGE_POSITIVE = 12'b0101_0101_0100;

  logic [7:0]  min_on;
  logic [7:0]  max_on;
  logic [3:0]  skip_when_off;
  logic [8:0]  on_volts;
  logic [11:0] refill_amount;
  logic [14:0] credit_ceiling;
  logic [9:0]  residual_limit;

  logic signed [8:0]  steps_left;
  logic signed [15:0] credit;
  logic               magnet_state;
  logic               health_state;
  logic [5:0]         charger_errs;

  res_t predicted_results[$];
  int   pending;
  int   mismatches;
  int   checked;
  int   fired;

  assign pending_count = pending;
  assign fail_count    = mismatches;
  assign checked_count = checked;
  assign fired_count   = fired;

  initial begin
    pending    = 0;
    mismatches = 0;
    checked    = 0;
    fired      = 0;
  end

  function automatic res_t step_sequencer(input item_t req);
    res_t res;
    int   n;
    int   skip_n;
    int   sum;
    int   idx;
    logic turning_on;
    logic positive;
    res = '0;
    if (req.op == OP_ON || req.op == OP_OFF) begin
      if (steps_left == 0 && credit >= 0) begin
        if (req.op == OP_ON) begin
          n = (req.pulse_count < min_on) ? min_on : req.pulse_count;
          if (n > max_on) n = max_on;
          steps_left = 9'(n);
        end else begin
          skip_n = 0;
          if (!magnet_state)
            skip_n = (skip_when_off > OFF_STEP_COUNT) ? OFF_STEP_COUNT : skip_when_off;
          steps_left = 9'(skip_n - OFF_STEP_COUNT);
        end
      end
    end else if (req.op == OP_POLL) begin
      if (req.refill_due) begin
        sum = int'(credit) + int'(refill_amount);
        if (sum > int'(credit_ceiling)) sum = credit_ceiling;
        credit = 16'(sum);
      end
      if (steps_left != 0) begin
        turning_on = steps_left > 0;
        positive   = 1'b1;
        if (turning_on) begin
          res.charge_target_volts = on_volts;
        end else begin
          idx = OFF_STEP_COUNT + steps_left;
          if (idx >= ROM_LEN) idx = ROM_LEN - 1;
          res.charge_target_volts = DISCHARGE_VOLTS[idx];
          positive = DISCHARGE_POSITIVE[idx];
        end
        charger_errs = req.charger_errors;
        case (req.charger_state)
          CHG_BUSY: begin
            if (credit != CREDIT_MIN) credit = credit - 16'sd1;
          end
          CHG_DONE: begin
            res.fire     = positive ? FIRE_POS : FIRE_NEG;
            magnet_state = turning_on;
            if (req.residual_volts > residual_limit) begin
              steps_left   = '0;
              health_state = 1'b1;
            end else begin
              steps_left   = turning_on ? steps_left - 9'sd1 : steps_left + 9'sd1;
              health_state = 1'b0;
            end
          end
          default: begin
            steps_left   = '0;
            health_state = 1'b1;
          end
        endcase
      end
    end
    res.magnet_on           = magnet_state;
    res.health_error        = health_state;
    res.charger_errors_seen = charger_errs;
    res.switching_on        = steps_left > 0;
    res.switching_off       = steps_left < 0;
    res.duty_credit         = credit;
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    item_t req;
    res_t  want;
    if (rst) begin
      min_on         = 8'd1;
      max_on         = 8'd10;
      skip_when_off  = 4'd0;
      on_volts       = 9'd475;
      refill_amount  = 12'd180;
      credit_ceiling = 15'd13000;
      residual_limit = 10'd100;
      steps_left     = '0;
      credit         = CREDIT_RESET;
      magnet_state   = 1'b0;
      health_state   = 1'b0;
      charger_errs   = '0;
      predicted_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MIN_ON:     min_on         = cfg_wdata[7:0];
          REG_MAX_PULSES: max_on         = cfg_wdata[7:0];
          REG_OFF_SKIP:   skip_when_off  = cfg_wdata[3:0];
          REG_ON_VOLTS:   on_volts       = cfg_wdata[8:0];
          REG_REFILL:     refill_amount  = cfg_wdata[11:0];
          REG_CREDIT_MAX: credit_ceiling = cfg_wdata[14:0];
          REG_RESID_FAIL: residual_limit = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        req.op             = s_tuser;
        req.pulse_count    = s_tdata[7:0];
        req.refill_due     = s_tdata[8];
        req.charger_state  = s_tdata[10:9];
        req.charger_errors = s_tdata[16:11];
        req.residual_volts = s_tdata[26:17];
        predicted_results.push_back(step_sequencer(req));
      end
      if (m_tvalid && m_tready) begin
        if (predicted_results.size() == 0) begin
          $error("result arrived with no request outstanding: %h", m_tdata);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          checked++;
          if (want.fire != FIRE_NONE) fired++;
          check_field("charge_target_volts", want.charge_target_volts, m_tdata[8:0]);
          check_field("fire", want.fire, m_tdata[10:9]);
          check_field("magnet_on", want.magnet_on, m_tdata[11]);
          check_field("health_error", want.health_error, m_tdata[12]);
          check_field("charger_errors_seen", want.charger_errors_seen, m_tdata[18:13]);
          check_field("switching_on", want.switching_on, m_tdata[19]);
          check_field("switching_off", want.switching_off, m_tdata[20]);
          check_field("duty_credit", int'(want.duty_credit),
                      int'($signed(m_tdata[36:21])));
        end
      end
    end
    pending = predicted_results.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mps_pkg::*;

  localparam int OFF_STEPS       = 12;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASE_REQUESTS  = 160;
  localparam int RANDOM_PHASES   = 6;
  localparam int DEBT_POLLS      = 250;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] CHG_TIMEOUT = 2'd2;
  localparam logic [1:0] CHG_UNKNOWN = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;
  logic                  cfg_wr_en;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int pending;
  int fail_count;
  int checked;
  int fired;

  int requests_sent  = 0;
  int settings_used  = 0;
  int resid_limit_now = 100;
  bit gaps_on        = 1'b1;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  magnet_pulse_sequencer_unit #(.OFF_STEPS(OFF_STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  magnet_sequencer_monitor #(.OFF_STEP_COUNT(OFF_STEPS)) seq_mon (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .pending_count(pending), .fail_count(fail_count),
    .checked_count(checked), .fired_count(fired)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(gaps_on && $urandom_range(99) < 27);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results outstanding", quiet_cycles, pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [7:0] count,
                              input logic refill, input logic [1:0] cstate,
                              input logic [5:0] cerr, input logic [9:0] resid);
    while (gaps_on && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'd0, resid, cerr, cstate, refill, count};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic poll(input logic refill, input logic [1:0] cstate,
                      input logic [5:0] cerr, input logic [9:0] resid);
    send_request(OP_POLL, 8'($urandom), refill, cstate, cerr, resid);
  endtask

  task automatic command(input logic [1:0] op, input logic [7:0] count);
    send_request(op, count, 1'b0, CHG_BUSY, 6'd0, 10'd0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic program_registers(input int min_on, input int max_on, input int skip,
                                   input int volts, input int refill, input int cmax,
                                   input int resid);
    int          vals [7];
    logic [2:0]  regs [7];
    vals = '{min_on, max_on, skip, volts, refill, cmax, resid};
    regs = '{REG_MIN_ON, REG_MAX_PULSES, REG_OFF_SKIP, REG_ON_VOLTS,
             REG_REFILL, REG_CREDIT_MAX, REG_RESID_FAIL};
    for (int i = 0; i < 7; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= CFG_DATA_W'(vals[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    resid_limit_now = resid;
    settings_used++;
  endtask

  task automatic random_poll();
    int         pick;
    logic [1:0] st;
    pick = $urandom_range(99);
    if (pick < 38)      st = CHG_BUSY;
    else if (pick < 92) st = CHG_DONE;
    else if (pick < 97) st = CHG_TIMEOUT;
    else                st = CHG_UNKNOWN;
    poll($urandom_range(99) < 20, st, 6'($urandom),
         10'(($urandom_range(99) < 88) ? $urandom_range(0, resid_limit_now)
                                       : $urandom_range(0, 1023)));
  endtask

  task automatic random_traffic(input int quota, input bit pause_midway);
    int sent_here;
    int polls;
    bit paused;
    sent_here = 0;
    paused    = 1'b0;
    while (sent_here < quota) begin
      if (pause_midway && !paused && sent_here >= quota / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 12) begin
        send_request(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                     2'($urandom), 6'($urandom), 10'($urandom));
        sent_here++;
      end else begin
        command(($urandom_range(99) < 55) ? OP_ON : OP_OFF,
                8'(($urandom_range(99) < 75) ? $urandom_range(0, 12)
                                             : $urandom_range(0, 255)));
        polls = $urandom_range(1, 16);
        repeat (polls) random_poll();
        sent_here += polls + 1;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_POLL;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MIN_ON;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings
    poll(1'b1, CHG_BUSY, 6'd0, 10'd0);
    send_request(OP_UNUSED, 8'hFF, 1'b1, CHG_UNKNOWN, 6'h3F, 10'h3FF);
    command(OP_ON, 8'd0);
    command(OP_ON, 8'd255);
    poll(1'b0, CHG_BUSY, 6'h3F, 10'd0);
    poll(1'b0, CHG_DONE, 6'h2A, 10'd0);
    command(OP_ON, 8'd255);
    poll(1'b0, CHG_DONE, 6'h15, 10'd101);
    command(OP_OFF, 8'd0);
    poll(1'b1, CHG_DONE, 6'd0, 10'd100);
    poll(1'b0, CHG_UNKNOWN, 6'h01, 10'd0);
    command(OP_OFF, 8'd0);
    poll(1'b0, CHG_TIMEOUT, 6'd0, 10'd0);

    // inverted clamp, oversized skip, ceiling below credit
    drain();
    program_registers(200, 20, 15, 511, 4095, 5000, 1023);
    poll(1'b1, CHG_BUSY, 6'd0, 10'd0);
    command(OP_ON, 8'd0);
    poll(1'b0, CHG_DONE, 6'd0, 10'h3FF);
    poll(1'b0, CHG_TIMEOUT, 6'd0, 10'd0);
    command(OP_OFF, 8'd0);
    poll(1'b0, CHG_DONE, 6'd0, 10'd0);
    poll(1'b0, CHG_TIMEOUT, 6'd0, 10'd0);
    command(OP_OFF, 8'd0);
    poll(1'b0, CHG_DONE, 6'd0, 10'd0);

    drain();
    program_registers(1, 0, 11, 511, 4095, 5000, 1023);
    command(OP_ON, 8'd9);
    command(OP_OFF, 8'd0);
    poll(1'b0, CHG_DONE, 6'd0, 10'd0);

    // drive the credit negative with no gaps
    drain();
    gaps_on = 1'b0;
    program_registers(1, 1, 0, 300, 0, 0, 1023);
    poll(1'b1, CHG_TIMEOUT, 6'd0, 10'd0);
    command(OP_ON, 8'd5);
    repeat (DEBT_POLLS) poll(1'($urandom_range(0, 1)), CHG_BUSY, 6'($urandom), 10'($urandom));
    poll(1'b0, CHG_TIMEOUT, 6'd0, 10'd0);
    command(OP_ON, 8'd1);
    command(OP_OFF, 8'd0);
    poll(1'b0, CHG_BUSY, 6'd0, 10'd0);
    drain();
    program_registers(1, 255, 0, 511, 4095, 32767, 1023);
    repeat (10) poll(1'b1, CHG_BUSY, 6'd0, 10'd0);
    command(OP_ON, 8'd1);
    poll(1'b0, CHG_DONE, 6'd0, 10'd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: program_registers(1, 255, 0, 511, 4095, 32767, 1023);
        1: program_registers(255, 1, 11, 0, 2, 0, 0);
        default: program_registers($urandom_range(0, 12), $urandom_range(0, 12),
                                   $urandom_range(0, 15), $urandom_range(0, 511),
                                   $urandom_range(0, 4095),
                                   ($urandom_range(1) == 1) ? $urandom_range(0, 400)
                                                            : $urandom_range(0, 32767),
                                   $urandom_range(0, 1023));
      endcase
      gaps_on = (p != 2);
      if (p == 3) hold_req = 1'b1;
      random_traffic(PHASE_REQUESTS, p == 4);
    end

    drain();
    repeat (8) @(negedge clk);

    $display("Sent %0d requests across %0d register settings, including a negative credit run",
             requests_sent, settings_used);
    $display("Checked %0d results, %0d of them firing a pulse", checked, fired);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
